// ===== design/assert_macros.svh =====
// assertion helpers used by the checker file p2mo_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, held off while reset is asserted
`define AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/p2mo_pkg.sv =====
`default_nettype none

package p2mo_pkg;

	// arithmetic width of exponent, modulus and results
	localparam int WIDTH = 32;
	localparam int BIT_W = $clog2(WIDTH);

	// stream word widths
	localparam int IN_TDATA_W  = 2 * WIDTH;
	localparam int OUT_TDATA_W = 3 * WIDTH;

	// field offsets inside the stream words
	localparam int IN_EXP_LO  = 0;
	localparam int IN_MOD_LO  = WIDTH;
	localparam int OUT_PW_LO  = 0;
	localparam int OUT_ORD_LO = WIDTH;
	localparam int OUT_REM_LO = 2 * WIDTH;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ORDER,
		ST_DIV,
		ST_SQ_DBL,
		ST_SQ_ADD,
		ST_POW_DBL,
		ST_FIN
	} p2mo_state_t;

endpackage

`default_nettype wire

// ===== design/power_of_two_mod_and_order.sv =====
// power_of_two_mod_and_order
//
// in channel: in_tvalid / in_tready / in_tdata, one word per job carrying the
//   exponent n (bits 31:0) and the modulus m (bits 63:32)
// out channel: out_tvalid / out_tready / out_tdata, one word per job carrying
//   2^n mod m (bits 31:0), the order of 2 mod m (bits 63:32) and n mod that
//   order (bits 95:64); order is 0 and the remainder is n for even m or m=1
// one job at a time: in_tready is high only while the sequencer is idle
// steps: m<=1 goes straight to the final state; otherwise an order search by
//   doubling (odd m only), a bit-serial remainder over the 32 exponent bits,
//   and square-and-multiply: 32 bit-serial squarings plus one doubling per set
//   exponent bit; the order can reach m-1
// everything runs through one modular add/compare/subtract unit, one
//   operation per cycle, which sets the throughput
// the result sits in an output register; the next job is accepted while it
//   waits, and a finished job holds in the final state until the register
//   frees up, so a stalled receiver stalls the block without losing a word
// reset (arst_n low) returns the sequencer to idle and drops out_tvalid

`default_nettype none

module power_of_two_mod_and_order (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_tvalid,
	output logic                            in_tready,
	input  wire [p2mo_pkg::IN_TDATA_W-1:0]  in_tdata,   // exponent, modulus
	output logic                            out_tvalid,
	input  wire                             out_tready,
	output logic [p2mo_pkg::OUT_TDATA_W-1:0] out_tdata  // power_mod, order_of_two, exp_mod_order
);

	import p2mo_pkg::*;

	p2mo_state_t state_q, state_d;

	// job registers
	logic [WIDTH-1:0] n_q, n_d;       // exponent as received
	logic [WIDTH-1:0] m_q, m_d;       // modulus
	logic [WIDTH-1:0] r_q, r_d;       // doubling value during search, then running power
	logic [WIDTH-1:0] k_q, k_d;       // order count
	logic [WIDTH-1:0] rem_q, rem_d;   // partial remainder, later exp_mod_order
	logic [WIDTH-1:0] e_q, e_d;       // exponent used by square-and-multiply
	logic [WIDTH-1:0] acc_q, acc_d;   // accumulator of the bit-serial squaring
	logic [BIT_W-1:0] ebit_q, ebit_d; // exponent bit, also remainder bit
	logic [BIT_W-1:0] mbit_q, mbit_d; // multiplier bit inside one squaring

	logic                   out_tvalid_q;
	logic [OUT_TDATA_W-1:0] out_tdata_q;
	logic                   out_load;

	// shared modular unit: (a + b + cin) mod d, valid for a, b < d
	logic [WIDTH-1:0] u_a, u_b, u_d;
	logic             u_cin;
	logic [WIDTH:0]   u_sum, u_diff;
	logic             u_ge;
	logic [WIDTH-1:0] u_res;

	logic             in_acc;
	logic             sq_adv;     // one multiplier bit of the squaring done
	logic [WIDTH-1:0] sq_v;       // accumulator value after that bit
	logic             nxt_ebit;   // move on to the next exponent bit

	assign in_tready  = (state_q == ST_IDLE);
	assign in_acc     = in_tvalid && in_tready;
	assign out_tvalid = out_tvalid_q;
	assign out_tdata  = out_tdata_q;
	assign out_load   = (state_q == ST_FIN) && (!out_tvalid_q || out_tready);

	// operand select for the shared unit
	always_comb begin
		u_a   = acc_q;
		u_b   = acc_q;
		u_cin = 1'b0;
		u_d   = m_q;
		unique case (state_q)
			ST_ORDER: begin
				u_a = r_q;
				u_b = r_q;
			end
			ST_DIV: begin
				// restoring division: shift in the next exponent bit
				u_a   = rem_q;
				u_b   = rem_q;
				u_cin = n_q[ebit_q];
				u_d   = k_q;
			end
			ST_SQ_DBL: begin
				u_a = acc_q;
				u_b = acc_q;
			end
			ST_SQ_ADD: begin
				u_a = acc_q;
				u_b = r_q;
			end
			ST_POW_DBL: begin
				u_a = r_q;
				u_b = r_q;
			end
			default: begin
				u_a = acc_q;
				u_b = acc_q;
			end
		endcase
	end

	assign u_sum  = {1'b0, u_a} + {1'b0, u_b} + {{WIDTH{1'b0}}, u_cin};
	assign u_ge   = (u_sum >= {1'b0, u_d});
	assign u_diff = u_sum - {1'b0, u_d};
	assign u_res  = u_ge ? u_diff[WIDTH-1:0] : u_sum[WIDTH-1:0];

	// sequencer
	always_comb begin
		state_d  = state_q;
		n_d      = n_q;
		m_d      = m_q;
		r_d      = r_q;
		k_d      = k_q;
		rem_d    = rem_q;
		e_d      = e_q;
		acc_d    = acc_q;
		ebit_d   = ebit_q;
		mbit_d   = mbit_q;
		sq_adv   = 1'b0;
		sq_v     = u_res;
		nxt_ebit = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					n_d   = in_tdata[IN_EXP_LO +: WIDTH];
					m_d   = in_tdata[IN_MOD_LO +: WIDTH];
					k_d   = '0;
					rem_d = in_tdata[IN_EXP_LO +: WIDTH];
					e_d   = in_tdata[IN_EXP_LO +: WIDTH];
					r_d   = {{(WIDTH-1){1'b0}}, 1'b1};
					acc_d = '0;
					ebit_d = BIT_W'(WIDTH - 1);
					mbit_d = BIT_W'(WIDTH - 1);
					priority if (in_tdata[IN_MOD_LO+1 +: WIDTH-1] == '0) begin
						// modulus zero or one
						r_d     = '0;
						state_d = ST_FIN;
					end else if (!in_tdata[IN_MOD_LO]) begin
						// even modulus: no order, power from the full exponent
						state_d = ST_SQ_DBL;
					end else begin
						state_d = ST_ORDER;
					end
				end
			end
			ST_ORDER: begin
				r_d = u_res;
				k_d = k_q + {{(WIDTH-1){1'b0}}, 1'b1};
				if (u_res == {{(WIDTH-1){1'b0}}, 1'b1}) begin
					rem_d   = '0;
					ebit_d  = BIT_W'(WIDTH - 1);
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				rem_d = u_res;
				if (ebit_q == '0) begin
					e_d     = u_res;
					r_d     = {{(WIDTH-1){1'b0}}, 1'b1};
					acc_d   = '0;
					ebit_d  = BIT_W'(WIDTH - 1);
					mbit_d  = BIT_W'(WIDTH - 1);
					state_d = ST_SQ_DBL;
				end else begin
					ebit_d = ebit_q - 1'b1;
				end
			end
			ST_SQ_DBL: begin
				if (r_q[mbit_q]) begin
					acc_d   = u_res;
					state_d = ST_SQ_ADD;
				end else begin
					sq_adv = 1'b1;
				end
			end
			ST_SQ_ADD: begin
				sq_adv = 1'b1;
			end
			ST_POW_DBL: begin
				r_d      = u_res;
				nxt_ebit = 1'b1;
			end
			ST_FIN: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// end of one multiplier bit of the squaring r*r
		if (sq_adv) begin
			if (mbit_q == '0) begin
				r_d = sq_v;
				if (e_q[ebit_q]) begin
					state_d = ST_POW_DBL;
				end else begin
					nxt_ebit = 1'b1;
				end
			end else begin
				mbit_d  = mbit_q - 1'b1;
				acc_d   = sq_v;
				state_d = ST_SQ_DBL;
			end
		end

		if (nxt_ebit) begin
			if (ebit_q == '0) begin
				state_d = ST_FIN;
			end else begin
				ebit_d  = ebit_q - 1'b1;
				mbit_d  = BIT_W'(WIDTH - 1);
				acc_d   = '0;
				state_d = ST_SQ_DBL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_tvalid_q <= 1'b1;
			end else if (out_tready) begin
				out_tvalid_q <= 1'b0;
			end
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		n_q    <= n_d;
		m_q    <= m_d;
		r_q    <= r_d;
		k_q    <= k_d;
		rem_q  <= rem_d;
		e_q    <= e_d;
		acc_q  <= acc_d;
		ebit_q <= ebit_d;
		mbit_q <= mbit_d;
		if (out_load) begin
			out_tdata_q[OUT_PW_LO  +: WIDTH] <= r_q;
			out_tdata_q[OUT_ORD_LO +: WIDTH] <= k_q;
			out_tdata_q[OUT_REM_LO +: WIDTH] <= rem_q;
		end
	end

endmodule

`default_nettype wire

// ===== design/p2mo_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module p2mo_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              in_tvalid,
	input wire                              in_tready,
	input wire                              out_tvalid,
	input wire                              out_tready,
	input wire [p2mo_pkg::OUT_TDATA_W-1:0]  out_tdata
);

	import p2mo_pkg::*;

	logic [WIDTH-1:0] ord_w, rem_w;

	assign ord_w = out_tdata[OUT_ORD_LO +: WIDTH];
	assign rem_w = out_tdata[OUT_REM_LO +: WIDTH];

	// a stalled result word stays offered
	`AST_NEXT(a_out_hold, clk, arst_n, out_tvalid && !out_tready, out_tvalid)
	// one job at a time: busy right after taking a word
	`AST_NEXT(a_busy_after_accept, clk, arst_n, in_tvalid && in_tready, !in_tready)
	// no result can appear in the cycle right after a word is taken
	`AST_NEXT(a_no_instant_result, clk, arst_n, in_tvalid && in_tready, !$rose(out_tvalid))
	// remainder is below a nonzero order, and the order of two is never one
	`AST_IMPLY(a_rem_below_order, clk, arst_n, out_tvalid && (ord_w != '0), rem_w < ord_w)
	`AST_IMPLY(a_order_not_one, clk, arst_n, out_tvalid, ord_w != {{(WIDTH-1){1'b0}}, 1'b1})

endmodule

bind power_of_two_mod_and_order p2mo_checker u_p2mo_checker (.*);

`default_nettype wire

// ===== tb/sv/power_of_two_mod_and_order_checker.sv =====
`timescale 1ns / 1ps

module power_of_two_mod_and_order_checker (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_tvalid,
	input  wire                              in_tready,
	input  wire [p2mo_pkg::IN_TDATA_W-1:0]   in_tdata,   // exponent, modulus
	input  wire                              out_tvalid,
	input  wire                              out_tready,
	input  wire [p2mo_pkg::OUT_TDATA_W-1:0]  out_tdata,  // power_mod, order_of_two, exp_mod_order
	output int                               mismatch_count,
	output int                               results_awaited
);

	localparam int W = p2mo_pkg::WIDTH;

	typedef logic [W-1:0] operand_t;

	typedef struct {
		operand_t power_mod;
		operand_t order_of_two;
		operand_t exp_mod_order;
	} p2mo_result_t;

	p2mo_result_t awaited_q[$];
	p2mo_result_t want;
	p2mo_result_t got;

	// square-and-multiply over every exponent bit, double-width products
	function automatic operand_t two_pow_mod(input operand_t e, input operand_t m);
		logic [2*W-1:0] acc;
		logic [2*W-1:0] base;
		logic [2*W-1:0] mm;
		mm = {{W{1'b0}}, m};
		acc = 1 % mm;
		base = 2 % mm;
		for (int i = 0; i < W; i++) begin
			if (e[i])
				acc = (acc * base) % mm;
			base = (base * base) % mm;
		end
		return acc[W-1:0];
	endfunction

	// least k >= 1 with 2^k == 1 mod m, found by doubling; odd m > 1 only
	function automatic operand_t doubling_order(input operand_t m);
		logic [W:0] x;
		operand_t k;
		x = 2;
		k = 1;
		while (x != 1) begin
			x = x << 1;
			if (x >= {1'b0, m})
				x = x - {1'b0, m};
			k++;
		end
		return k;
	endfunction

	function automatic p2mo_result_t predict_power_order(input operand_t n, input operand_t m);
		p2mo_result_t r;
		if (m <= 1) begin
			r.power_mod = '0;
			r.order_of_two = '0;
			r.exp_mod_order = n;
		end else if (!m[0]) begin
			r.order_of_two = '0;
			r.exp_mod_order = n;
			r.power_mod = two_pow_mod(n, m);
		end else begin
			r.order_of_two = doubling_order(m);
			r.exp_mod_order = n % r.order_of_two;
			r.power_mod = two_pow_mod(r.exp_mod_order, m);
		end
		return r;
	endfunction

	task automatic check_field(input string name, input operand_t exp_val, input operand_t act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_q.delete();
			mismatch_count = 0;
			results_awaited = 0;
		end else begin
			// retire before predicting: a word leaving now belongs to an older job
			if (out_tvalid && out_tready) begin
				got.power_mod = out_tdata[p2mo_pkg::OUT_PW_LO +: W];
				got.order_of_two = out_tdata[p2mo_pkg::OUT_ORD_LO +: W];
				got.exp_mod_order = out_tdata[p2mo_pkg::OUT_REM_LO +: W];
				if (awaited_q.size() == 0) begin
					$display("%0t: result word %0h with none expected", $time, out_tdata);
					mismatch_count++;
				end else begin
					want = awaited_q.pop_front();
					check_field("power_mod", want.power_mod, got.power_mod);
					check_field("order_of_two", want.order_of_two, got.order_of_two);
					check_field("exp_mod_order", want.exp_mod_order, got.exp_mod_order);
				end
			end
			if (in_tvalid && in_tready)
				awaited_q.push_back(predict_power_order(in_tdata[p2mo_pkg::IN_EXP_LO +: W],
					in_tdata[p2mo_pkg::IN_MOD_LO +: W]));
			results_awaited = awaited_q.size();
		end
	end

endmodule

// ===== tb/sv/power_of_two_mod_and_order_test.sv =====
`timescale 1ns / 1ps

module power_of_two_mod_and_order_test;

	localparam int W = p2mo_pkg::WIDTH;
	// the watchdog limit covers a whole job plus the order search (the order
	// stays under 1100 here); the long receiver hold-off is below it as well
	localparam int QUIET_LIMIT = 40000;
	localparam int HOLD_CYCLES = 3000;
	localparam int DRAIN_CYCLES = 3000;
	localparam int JOBS_PER_PHASE = 282;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             in_tvalid;
	logic                             in_tready;
	logic [p2mo_pkg::IN_TDATA_W-1:0]  in_tdata;   // exponent, modulus
	logic                             out_tvalid;
	logic                             out_tready;
	logic [p2mo_pkg::OUT_TDATA_W-1:0] out_tdata;  // power_mod, order_of_two, exp_mod_order

	int mismatch_count;
	int results_awaited;

	// idling knobs, percent of cycles
	int idle_pct = 0;
	int stall_pct = 0;
	// one long receiver hold-off, requested by the stimulus
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int quiet_cycles = 0;

	power_of_two_mod_and_order uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_tvalid  (in_tvalid),
		.in_tready  (in_tready),
		.in_tdata   (in_tdata),
		.out_tvalid (out_tvalid),
		.out_tready (out_tready),
		.out_tdata  (out_tdata)
	);

	power_of_two_mod_and_order_checker check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_tvalid       (in_tvalid),
		.in_tready       (in_tready),
		.in_tdata        (in_tdata),
		.out_tvalid      (out_tvalid),
		.out_tready      (out_tready),
		.out_tdata       (out_tdata),
		.mismatch_count  (mismatch_count),
		.results_awaited (results_awaited)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver: random stalls, plus one long hold-off counted here
	initial begin
		out_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				out_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// watchdog: cycles with no word moving on either side
	always @(posedge clk) begin
		if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: timeout, no handshake for %0d cycles", $time, quiet_cycles);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offer one job word; returns at the falling edge after it was taken
	task automatic send_job(input logic [W-1:0] n, input logic [W-1:0] m);
		while ($urandom_range(99) < idle_pct) begin
			in_tvalid <= 1'b0;
			@(negedge clk);
		end
		in_tvalid <= 1'b1;
		in_tdata <= {m, n};
		do
			@(posedge clk);
		while (!in_tready);
		@(negedge clk);
	endtask

	initial begin
		int sel;
		int k;
		logic [W-1:0] n;
		logic [W-1:0] m;
		logic [2*W-1:0] wide;

		in_tvalid = 1'b0;
		in_tdata = '0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// modulus one, exponent extremes
		send_job(32'h0000_0000, 32'd1);
		send_job(32'hFFFF_FFFF, 32'd1);
		// exponent zero with odd and even moduli
		send_job(32'h0000_0000, 32'd3);
		send_job(32'h0000_0000, 32'd2);
		send_job(32'h0000_0000, 32'h8000_0000);
		send_job(32'h0000_0000, 32'hFFFF_FFFF);
		// smallest even modulus, power vanishes
		send_job(32'd5, 32'd2);
		// largest modulus, odd, order 32
		send_job(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// largest even modulus, full exponent used
		send_job(32'hFFFF_FFFF, 32'hFFFF_FFFE);
		// power-of-two modulus at the top bit
		send_job(32'd31, 32'h8000_0000);
		send_job(32'd30, 32'h8000_0000);
		// 2^31+1 has order 62: multiple of the order and a large exponent
		send_job(32'd62, 32'h8000_0001);
		send_job(32'h8000_0000, 32'h8000_0001);
		// small odd moduli, and 2^31-1
		send_job(32'd1, 32'd3);
		send_job(32'd2, 32'd3);
		send_job(32'd100, 32'd7);
		send_job(32'hFFFF_FFFF, 32'd1023);
		send_job(32'd12345, 32'd1021);
		send_job(32'hAAAA_AAAA, 32'h7FFF_FFFF);
		// small even moduli, one with alternating exponent bits
		send_job(32'h7FFF_FFFF, 32'd6);
		send_job(32'h5555_5555, 32'd12);
		send_job(32'd33, 32'd256);

		// phases: none, sender idle, receiver stall, both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
					// the long hold-off lands while the sender keeps offering
					hold_req = 1'b1;
				end
				1: begin
					idle_pct = 61;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 61;
				end
				default: begin
					idle_pct = 29;
					stall_pct = 29;
				end
			endcase
			for (int j = 0; j < JOBS_PER_PHASE; j++) begin
				// modulus: keep the order search short, odd moduli are small
				// unless they are 2^k-1 or 2^k+1, whose order is tiny
				sel = $urandom_range(99);
				if (sel < 35) begin
					m = ($urandom_range(511) << 1) | 1;
				end else if (sel < 65) begin
					m = $urandom & ~32'd1;
					if (m == 0)
						m = 32'd2;
				end else if (sel < 78) begin
					k = $urandom_range(32, 2);
					wide = (64'd1 << k) - 1;
					m = wide[W-1:0];
				end else if (sel < 88) begin
					k = $urandom_range(31, 1);
					wide = (64'd1 << k) + 1;
					m = wide[W-1:0];
				end else if (sel < 95) begin
					m = 32'd1 << $urandom_range(31, 1);
				end else begin
					m = $urandom_range(16, 1);
				end
				// exponent: full range, small, or near the top
				sel = $urandom_range(99);
				if (sel < 60)
					n = $urandom;
				else if (sel < 80)
					n = $urandom_range(70);
				else
					n = 32'hFFFF_FFFF - $urandom_range(63);
				send_job(n, m);
			end
		end
		in_tvalid <= 1'b0;

		// drain, then allow a job's worth of cycles for anything stray
		wait (results_awaited == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== power_of_two_mod_and_order.f =====
+incdir+design
design/p2mo_pkg.sv
design/power_of_two_mod_and_order.sv
design/p2mo_checker.sv
tb/sv/power_of_two_mod_and_order_checker.sv
tb/sv/power_of_two_mod_and_order_test.sv
